FILE: hdl/rlpe_pkg.sv
// ----------------------------------------------------------------------------
// rlpe_pkg
// shared types, constants and helpers of the rgb led pwm bit encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rlpe_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned BRIGHT_W      = 7;
  localparam int unsigned DUTY_W        = 16;
  localparam int unsigned SLOT_W        = 6;
  localparam int unsigned WORD_W        = 3 * CHAN_W;
  localparam int unsigned BIT_CNT_W     = 5;
  localparam int unsigned PROD_W        = CHAN_W + BRIGHT_W;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [BRIGHT_W-1:0]  PERCENT_FULL    = 7'd100;
  localparam logic [SLOT_W-1:0]    MAX_RESET_SLOTS = 6'd40;
  localparam logic [BIT_CNT_W-1:0] TOP_BIT         = 5'd23;

  // reciprocal of 100 scaled by 2^19, exact for products up to 255 * 100
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned MUL_W = PROD_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_DUTY_ONE   = 2'd1,
    REG_DUTY_ZERO  = 2'd2,
    REG_SLOTS      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_zero;
    logic [SLOT_W-1:0] slots;
  } ser_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] grb;
    logic              last;
  } led_word_t;

  function automatic logic [CHAN_W-1:0] div100(input logic [PROD_W-1:0] p);
    logic [MUL_W-1:0] m;
    m = MUL_W'(p) * MUL_W'(RECIP_100);
    return m[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rlpe_scale.sv
// ----------------------------------------------------------------------------
// rlpe_scale
// two-stage brightness scaler: channel times percent, then divide by 100
// ----------------------------------------------------------------------------
`default_nettype none

module rlpe_scale (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [rlpe_pkg::BRIGHT_W-1:0]   brightness,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rlpe_pkg::CHAN_W-1:0]     red,
  input  wire logic [rlpe_pkg::CHAN_W-1:0]     green,
  input  wire logic [rlpe_pkg::CHAN_W-1:0]     blue,
  input  wire logic                            final_led,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rlpe_pkg::led_word_t                  out_word
);
  import rlpe_pkg::*;

  logic              s1_valid;
  logic [PROD_W-1:0] p_red;
  logic [PROD_W-1:0] p_green;
  logic [PROD_W-1:0] p_blue;
  logic              s1_last;

  logic              s2_valid;
  led_word_t         s2_word;

  logic              s1_ready;
  logic              s2_ready;
  logic              take;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign take     = in_valid && s1_ready;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_red   <= PROD_W'(red) * PROD_W'(brightness);
      p_green <= PROD_W'(green) * PROD_W'(brightness);
      p_blue  <= PROD_W'(blue) * PROD_W'(brightness);
      s1_last <= final_led;
    end
  end

  // stage 2: divide by 100 and pack as green, red, blue
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_word.grb  <= {div100(p_green), div100(p_red), div100(p_blue)};
      s2_word.last <= s1_last;
    end
  end

  assign out_valid = s2_valid;
  assign out_word  = s2_word;

endmodule

`default_nettype wire

FILE: hdl/rlpe_serial.sv
// ----------------------------------------------------------------------------
// rlpe_serial
// word buffer and bit serialiser: one duty value per cycle, with a final word followed by reset slots
// ----------------------------------------------------------------------------
`default_nettype none

module rlpe_serial (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rlpe_pkg::ser_cfg_t            cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rlpe_pkg::led_word_t           in_word,
  output logic                               strobe,
  output logic [rlpe_pkg::DUTY_W-1:0]        duty_value,
  output logic                               end_of_run
);
  import rlpe_pkg::*;

  logic                 buf_valid;
  led_word_t            buf_word;

  logic                 active;
  logic                 in_slot;
  logic [WORD_W-1:0]    shreg;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [SLOT_W-1:0]    slot_left;

  logic                 finish;
  logic                 load;
  logic                 buf_ready;

  always_comb begin
    if (in_slot) begin
      duty_value = '0;
      end_of_run = (slot_left == SLOT_W'(1));
    end else begin
      duty_value = shreg[WORD_W-1] ? cfg.duty_one : cfg.duty_zero;
      end_of_run = (bit_cnt == TOP_BIT) && (slot_left == '0);
    end
  end

  assign strobe    = active;
  assign finish    = active && end_of_run;
  assign load      = buf_valid && (!active || finish);
  assign buf_ready = !buf_valid || load;
  assign in_ready  = buf_ready;

  // single-entry buffer so the scaler keeps going while a word is shifted out
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (buf_ready) begin
      buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_ready && in_valid) begin
      buf_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      in_slot <= 1'b0;
    end else if (load) begin
      active  <= 1'b1;
      in_slot <= 1'b0;
    end else if (finish) begin
      active  <= 1'b0;
      in_slot <= 1'b0;
    end else if (active && !in_slot && bit_cnt == TOP_BIT) begin
      in_slot <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg     <= buf_word.grb;
      bit_cnt   <= '0;
      slot_left <= buf_word.last ? cfg.slots : '0;
    end else if (active) begin
      if (in_slot) begin
        slot_left <= slot_left - SLOT_W'(1);
      end else if (bit_cnt != TOP_BIT) begin
        shreg   <= {shreg[WORD_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
    end
  end

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    active |-> bit_cnt <= TOP_BIT)
    else $error("bit counter past the last bit");

  a_slot_live: assert property (@(posedge clk) disable iff (rst)
    active && in_slot |-> slot_left != '0)
    else $error("reset slot phase with no slots left");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    finish && !buf_valid |=> !active)
    else $error("serialiser kept running after its last result");

  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> active && !in_slot && bit_cnt == '0)
    else $error("word load did not restart the bit sequence");

endmodule

`default_nettype wire

FILE: hdl/rgb_led_pwm_bit_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_pwm_bit_encoder
// ws2812 style pwm bit encoder with brightness scaling and reset slots
// ----------------------------------------------------------------------------
// An item (red, green, blue, final_led) is taken at a clock edge where start
// is high and busy is low. Each channel is scaled by the brightness percent,
// packed green-red-blue and sent msb first as one duty value per cycle on
// duty_value, marked by strobe. After an item with final_led set, the
// configured number of zero-duty reset slots follows. end_of_run marks the
// last result of each item. The receiver cannot stall: every strobe cycle
// is a delivered result.
// The first result of an item passes the multiply stage, the divide-by-100
// stage and the word buffer before the serialiser loads it, when the
// serialiser is free. It gives one result per cycle, so an item holds it while
// its 24 bits, plus the reset slots with final_led set, are sent; the serialiser
// sets the rate and busy rises once the scaler stages and buffer are full.
// Registers are written via wr_en, wr_index, wr_data; brightness and slots
// take the low 7 and 6 bits of wr_data, clamped to 100 and 40. Synchronous
// reset (rst) empties the pipeline, sets brightness 100, duties 0, 40 reset slots.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pwm_bit_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [rlpe_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [rlpe_pkg::CFG_DATA_W-1:0]   wr_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [rlpe_pkg::CHAN_W-1:0]       red,
  input  wire logic [rlpe_pkg::CHAN_W-1:0]       green,
  input  wire logic [rlpe_pkg::CHAN_W-1:0]       blue,
  input  wire logic                              final_led,
  output logic                                   strobe,
  output logic [rlpe_pkg::DUTY_W-1:0]            duty_value,
  output logic                                   end_of_run
);
  import rlpe_pkg::*;

  logic [BRIGHT_W-1:0] brightness_percent;
  ser_cfg_t            ser_cfg;

  logic [BRIGHT_W-1:0] wr_bright;
  logic [SLOT_W-1:0]   wr_slots;

  logic                in_ready;
  logic                word_valid;
  logic                word_ready;
  led_word_t           word;

  assign wr_bright = wr_data[BRIGHT_W-1:0];
  assign wr_slots  = wr_data[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_percent <= PERCENT_FULL;
      ser_cfg.duty_one   <= '0;
      ser_cfg.duty_zero  <= '0;
      ser_cfg.slots      <= MAX_RESET_SLOTS;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_BRIGHTNESS: begin
          brightness_percent <= (wr_bright > PERCENT_FULL) ? PERCENT_FULL : wr_bright;
        end
        REG_DUTY_ONE: begin
          ser_cfg.duty_one <= wr_data[DUTY_W-1:0];
        end
        REG_DUTY_ZERO: begin
          ser_cfg.duty_zero <= wr_data[DUTY_W-1:0];
        end
        REG_SLOTS: begin
          ser_cfg.slots <= (wr_slots > MAX_RESET_SLOTS) ? MAX_RESET_SLOTS : wr_slots;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = !in_ready;

  rlpe_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .brightness (brightness_percent),
    .in_valid   (start),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .final_led  (final_led),
    .out_valid  (word_valid),
    .out_ready  (word_ready),
    .out_word   (word)
  );

  rlpe_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .cfg        (ser_cfg),
    .in_valid   (word_valid),
    .in_ready   (word_ready),
    .in_word    (word),
    .strobe     (strobe),
    .duty_value (duty_value),
    .end_of_run (end_of_run)
  );

endmodule

`default_nettype wire
